// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Item kind carried in the input tuser.
    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // Result code carried in the output tuser.
    typedef enum logic [1:0] {
        RES_ENQ   = 2'd0,
        RES_DEQ   = 2'd1,
        RES_EMPTY = 2'd2,
        RES_FULL  = 2'd3
    } res_t;

    // Datapath operation on the sorted entry chain.
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_EXEC = 1'b1
    } ctrl_state_t;

    localparam int unsigned PRIO_BITS    = 16;
    localparam int unsigned IN_PAY_BITS  = 32;
    localparam int unsigned OCC_BITS     = 5;
    localparam int unsigned OUT_PAY_BITS = 32;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // register the accepted input item
        logic load_out;  // execute op and load the result register
        op_t  op;
        res_t code;
    } spq_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_deq;
        logic empty;
        logic full;
    } spq_sts_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Two-state sequencer: accept an item, then execute it into the result register.
// ----------------------------------------------------------------------------
module spq_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  spq_pkg::spq_sts_t  sts,
    output spq_pkg::spq_cmd_t  cmd
);

    spq_pkg::ctrl_state_t state_reg;
    spq_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 can_load;

    // Result register is free, or is being emptied this cycle.
    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spq_pkg::CTRL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = spq_pkg::CTRL_EXEC;
                end
            end
            spq_pkg::CTRL_EXEC:
            begin
                if (can_load)
                begin
                    state_next = spq_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.op       = spq_pkg::OP_HOLD;
        cmd.code     = spq_pkg::RES_ENQ;
        case (state_reg)
            spq_pkg::CTRL_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            spq_pkg::CTRL_EXEC:
            begin
                cmd.load_out = can_load;
                if (sts.is_deq)
                begin
                    if (sts.empty)
                    begin
                        cmd.code = spq_pkg::RES_EMPTY;
                    end
                    else
                    begin
                        cmd.op   = can_load ? spq_pkg::OP_POP : spq_pkg::OP_HOLD;
                        cmd.code = spq_pkg::RES_DEQ;
                    end
                end
                else
                begin
                    if (sts.full)
                    begin
                        cmd.code = spq_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.op   = can_load ? spq_pkg::OP_PUSH : spq_pkg::OP_HOLD;
                        cmd.code = spq_pkg::RES_ENQ;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is produced only while an item is in execution.
    a_load_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> state_reg == spq_pkg::CTRL_EXEC)
        else $error("result load outside execute state");

    // Never insert into a full chain, never remove from an empty one.
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == spq_pkg::OP_PUSH |-> !sts.full && !sts.is_deq)
        else $error("push issued on full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == spq_pkg::OP_POP |-> !sts.empty && sts.is_deq)
        else $error("pop issued on empty queue");

    // An accepted item is executed on the next cycle or later, not dropped.
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == spq_pkg::CTRL_EXEC)
        else $error("captured item not executed");

endmodule

// ===== hdl/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp
// Sorted entry chain with parallel compare-and-shift, input and result registers.
// ----------------------------------------------------------------------------
module spq_dp
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned PAYLOAD_BITS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  spq_pkg::spq_cmd_t                   cmd,
    output spq_pkg::spq_sts_t                   sts,
    input  logic                                in_kind,
    input  logic [spq_pkg::IN_PAY_BITS-1:0]     in_payload,
    input  logic [spq_pkg::PRIO_BITS-1:0]       in_priority,
    output logic [spq_pkg::OUT_PAY_BITS-1:0]    out_payload,
    output spq_pkg::res_t                       out_status,
    output logic [spq_pkg::OCC_BITS-1:0]        out_occupancy
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Captured item.
    logic                            kind_reg;
    logic [PAYLOAD_BITS-1:0]         pay_in_reg;
    logic [spq_pkg::PRIO_BITS-1:0]   prio_in_reg;

    // Entry chain, head at index 0.
    logic [spq_pkg::PRIO_BITS-1:0]   prio_reg  [DEPTH];
    logic [spq_pkg::PRIO_BITS-1:0]   prio_next [DEPTH];
    logic [PAYLOAD_BITS-1:0]         pay_reg   [DEPTH];
    logic [PAYLOAD_BITS-1:0]         pay_next  [DEPTH];
    logic [DEPTH-1:0]                le;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;

    // Result register.
    logic [spq_pkg::OUT_PAY_BITS-1:0] res_pay_reg;
    spq_pkg::res_t                    res_code_reg;
    logic [spq_pkg::OCC_BITS-1:0]     res_occ_reg;

    logic [PAYLOAD_BITS+spq_pkg::IN_PAY_BITS-1:0]  in_pay_ext;
    logic [PAYLOAD_BITS+spq_pkg::OUT_PAY_BITS-1:0] head_pay_ext;
    logic [CW+spq_pkg::OCC_BITS-1:0]               occ_ext;

    assign in_pay_ext   = {{PAYLOAD_BITS{1'b0}}, in_payload};
    assign head_pay_ext = {{spq_pkg::OUT_PAY_BITS{1'b0}}, pay_reg[0]};
    assign occ_ext      = {{spq_pkg::OCC_BITS{1'b0}}, count_next};

    assign sts.is_deq = (kind_reg == spq_pkg::KIND_DEQ);
    assign sts.empty  = (count_reg == '0);
    assign sts.full   = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg    <= in_kind;
            pay_in_reg  <= in_pay_ext[PAYLOAD_BITS-1:0];
            prio_in_reg <= in_priority;
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);

            // Valid entry that the new item goes behind.
            assign le[g] = (IDX < count_reg) && (prio_reg[g] <= prio_in_reg);

            always_comb
            begin
                prio_next[g] = prio_reg[g];
                pay_next[g]  = pay_reg[g];
                case (cmd.op)
                    spq_pkg::OP_PUSH:
                    begin
                        if (!le[g])
                        begin
                            if (g == 0)
                            begin
                                prio_next[g] = prio_in_reg;
                                pay_next[g]  = pay_in_reg;
                            end
                            else if (le[(g == 0) ? 0 : g-1])
                            begin
                                prio_next[g] = prio_in_reg;
                                pay_next[g]  = pay_in_reg;
                            end
                            else
                            begin
                                prio_next[g] = prio_reg[(g == 0) ? 0 : g-1];
                                pay_next[g]  = pay_reg[(g == 0) ? 0 : g-1];
                            end
                        end
                    end
                    spq_pkg::OP_POP:
                    begin
                        if (g < DEPTH - 1)
                        begin
                            prio_next[g] = prio_reg[(g < DEPTH - 1) ? g+1 : g];
                            pay_next[g]  = pay_reg[(g < DEPTH - 1) ? g+1 : g];
                        end
                    end
                    default:
                    begin
                        prio_next[g] = prio_reg[g];
                    end
                endcase
            end

            always_ff @(posedge clk)
            begin
                prio_reg[g] <= prio_next[g];
                pay_reg[g]  <= pay_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        case (cmd.op)
            spq_pkg::OP_PUSH: count_next = count_reg + 1'b1;
            spq_pkg::OP_POP:  count_next = count_reg - 1'b1;
            default:          count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_pay_reg  <= (cmd.op == spq_pkg::OP_POP) ?
                            head_pay_ext[spq_pkg::OUT_PAY_BITS-1:0] : '0;
            res_code_reg <= cmd.code;
            res_occ_reg  <= occ_ext[spq_pkg::OCC_BITS-1:0];
        end
    end

    assign out_payload   = res_pay_reg;
    assign out_status    = res_code_reg;
    assign out_occupancy = res_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == spq_pkg::OP_POP |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not decrement count");

    a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == spq_pkg::OP_PUSH |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not increment count");

endmodule

// ===== hdl/stable_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue held as a sorted register chain, stable among equals.
// ----------------------------------------------------------------------------
// Each input transfer is an enqueue (tuser 0) or a dequeue (tuser 1) and gives
// exactly one output transfer. Entries sit in a chain of DEPTH registers kept
// sorted by priority, lowest number at the head; every cell compares its own
// priority with the new one in parallel, so an enqueue lands behind all
// entries of lower or equal priority in one shift and equal priorities leave
// in arrival order. A dequeue shifts the chain toward the head and returns the
// head payload. Each item is first registered from the input transfer, then
// executed: the chain is updated and the output register loaded. No new item
// is accepted until it has executed, but one is accepted while a result still
// waits in the output register; execution holds only if that register is still full.
// Output tuser: 0 enqueued, 1 dequeued, 2 queue empty, 3 queue full (dropped).
// Occupancy is the entry count after the item; payload is zero unless tuser 1.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned PAYLOAD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] payload, [47:32] priority_req
    input  logic        s_axis_tuser,   // [0] kind
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] out_payload, [36:32] occupancy, [39:37] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    spq_pkg::spq_cmd_t                cmd;
    spq_pkg::spq_sts_t                sts;
    logic [spq_pkg::OUT_PAY_BITS-1:0] res_payload;
    spq_pkg::res_t                    res_status;
    logic [spq_pkg::OCC_BITS-1:0]     res_occupancy;

    // Sequence each transfer: capture, then execute into the output register.
    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Sorted chain, count and result register.
    spq_dp
    #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (s_axis_tuser),
        .in_payload    (s_axis_tdata[31:0]),
        .in_priority   (s_axis_tdata[47:32]),
        .out_payload   (res_payload),
        .out_status    (res_status),
        .out_occupancy (res_occupancy)
    );

    // Pack the result fields, pad to whole bytes.
    assign m_axis_tdata = {3'b000, res_occupancy, res_payload};
    assign m_axis_tuser = res_status;

endmodule
